FILE: design/tes_pkg.sv
// Package: shared types and constants of the timed event scheduler.
`timescale 1ns / 1ps
package tes_pkg;
   localparam int QueueDepth = 16;
   localparam int MaxResults = 16;
   localparam int SlotBits   = $clog2(QueueDepth);
   localparam int CountBits  = $clog2(MaxResults + 1);

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_FINISH = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_FIRED    = 3'd1,
      ST_REMOVED  = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4,
      ST_NONE     = 3'd5
   } status_type;

   // Command passed from the front end to the execution engine.
   typedef struct packed {
      action_type  action;
      logic [31:0] duration_ms;
      logic        periodic;
      logic [31:0] target_id;
      logic [31:0] elapsed_ms;
   } cmd_type;

   typedef enum logic [2:0] {
      EX_IDLE,
      EX_SCAN,
      EX_EMIT,
      EX_FINAL
   } exec_state_type;
endpackage

FILE: design/tes_cmd_fifo.sv
// Two-entry command queue between the front end and the execution engine.
`timescale 1ns / 1ps
module tes_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_stall,
   input  tes_pkg::cmd_type wr_cmd,
   output logic             rd_valid,
   input  logic             rd_take,
   output tes_pkg::cmd_type rd_cmd
);
   import tes_pkg::*;

   cmd_type    mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign wr_stall = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_cmd   = mem_ff[rptr_ff];
   assign push     = wr_valid && !wr_stall;
   assign pop      = rd_take && rd_valid;

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= wr_cmd;
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("fifo count out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push) else $error("push into full fifo");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 2'd1) else $error("pop miscount");
`endif
endmodule

FILE: design/tes_exec.sv
// Execution engine: event table, scans for add, remove and tick; finish needs none.
`timescale 1ns / 1ps
module tes_exec (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  tes_pkg::cmd_type  cmd,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_event_id,
   output logic [2:0]        rsp_status,
   output logic              rsp_last
);
   import tes_pkg::*;

   exec_state_type state_ff, state_in;
   cmd_type        cur_ff, cur_in;
   logic [47:0]    now_ff, now_in;
   logic [31:0]    next_id_ff, next_id_in;
   logic [QueueDepth-1:0] valid_ff, valid_in;
   logic [QueueDepth-1:0] fired_ff, fired_in;
   logic [47:0]    due_ff    [QueueDepth];
   logic [31:0]    period_ff [QueueDepth];
   logic           perio_ff  [QueueDepth];
   logic [31:0]    id_ff     [QueueDepth];

   logic [SlotBits-1:0]  idx_ff, idx_in;
   logic                 found_ff, found_in;
   logic [SlotBits-1:0]  best_ff, best_in;
   logic [CountBits-1:0] n_ff, n_in;
   logic [CountBits-1:0] cnt_ff, cnt_in;

   logic        ovalid_ff, ovalid_in;
   logic [31:0] oid_ff, oid_in;
   logic [2:0]  ost_ff, ost_in;
   logic        olast_ff, olast_in;

   logic                 out_free;
   logic [SlotBits-1:0]  slot;
   logic                 cand;
   logic                 better;
   logic                 wr_add, wr_fire, wr_finish;
   logic [47:0]          fire_due;

   assign rsp_valid    = ovalid_ff;
   assign rsp_event_id = oid_ff;
   assign rsp_status   = ost_ff;
   assign rsp_last     = olast_ff;
   assign out_free     = !ovalid_ff || !rsp_stall;
   assign slot         = idx_ff;

   // Due and not yet fired this tick.
   assign cand   = valid_ff[slot] && !fired_ff[slot] && (due_ff[slot] <= now_ff);
   assign better = !found_ff || (due_ff[slot] < due_ff[best_ff]) ||
                   (due_ff[slot] == due_ff[best_ff] && id_ff[slot] < id_ff[best_ff]);

   always_comb begin
      fire_due = now_ff;
      if (period_ff[best_ff] != 32'd0)
         fire_due = due_ff[best_ff] + {16'd0, period_ff[best_ff]};
   end

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      now_in     = now_ff;
      next_id_in = next_id_ff;
      valid_in   = valid_ff;
      fired_in   = fired_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      n_in       = n_ff;
      cnt_in     = cnt_ff;
      ovalid_in  = ovalid_ff && rsp_stall;
      oid_in     = oid_ff;
      ost_in     = ost_ff;
      olast_in   = olast_ff;
      cmd_take   = 1'b0;
      wr_add     = 1'b0;
      wr_fire    = 1'b0;
      wr_finish  = 1'b0;
      unique case (state_ff)
         EX_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cur_in   = cmd;
               idx_in   = '0;
               found_in = 1'b0;
               best_in  = '0;
               n_in     = '0;
               cnt_in   = '0;
               fired_in = '0;
               if (cmd.action == ACT_TICK)
                  now_in = now_ff + {16'd0, cmd.elapsed_ms};
               state_in = (cmd.action == ACT_FINISH) ? EX_FINAL : EX_SCAN;
            end
         end
         EX_SCAN: begin
            // Walk one slot per cycle.
            unique case (cur_ff.action)
               ACT_ADD: if (!valid_ff[slot] && !found_ff) begin
                  found_in = 1'b1;
                  best_in  = slot;
               end
               ACT_REMOVE: if (valid_ff[slot] && id_ff[slot] == cur_ff.target_id
                               && !found_ff) begin
                  found_in = 1'b1;
                  best_in  = slot;
               end
               default: begin
                  // Count what is still due so the final fire can carry last.
                  cnt_in = cnt_ff + {{(CountBits-1){1'b0}}, cand};
                  if (cand && better) begin
                     found_in = 1'b1;
                     best_in  = slot;
                  end
               end
            endcase
            idx_in = idx_ff + 1'b1;
            if (idx_ff == SlotBits'(QueueDepth - 1)) state_in = EX_EMIT;
         end
         EX_EMIT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               olast_in  = 1'b1;
               state_in  = EX_IDLE;
               unique case (cur_ff.action)
                  ACT_ADD: begin
                     if (found_ff) begin
                        wr_add     = 1'b1;
                        valid_in[best_ff] = 1'b1;
                        oid_in     = next_id_ff;
                        ost_in     = ST_ADDED;
                        next_id_in = next_id_ff + 32'd1;
                     end else begin
                        oid_in = 32'd0;
                        ost_in = ST_FULL;
                     end
                  end
                  ACT_REMOVE: begin
                     oid_in = cur_ff.target_id;
                     if (found_ff) begin
                        valid_in[best_ff] = 1'b0;
                        ost_in = ST_REMOVED;
                     end else begin
                        ost_in = ST_NOTFOUND;
                     end
                  end
                  default: begin
                     if (found_ff) begin
                        wr_fire = 1'b1;
                        fired_in[best_ff] = 1'b1;
                        if (!perio_ff[best_ff]) valid_in[best_ff] = 1'b0;
                        oid_in = id_ff[best_ff];
                        ost_in = ST_FIRED;
                        n_in   = n_ff + 1'b1;
                        if (n_ff == CountBits'(MaxResults - 1) ||
                            cnt_ff == CountBits'(1)) begin
                           olast_in = 1'b1;
                        end else begin
                           olast_in = 1'b0;
                           state_in = EX_SCAN;
                           idx_in   = '0;
                           found_in = 1'b0;
                           cnt_in   = '0;
                        end
                     end else begin
                        oid_in = 32'd0;
                        ost_in = ST_NONE;
                     end
                  end
               endcase
            end
         end
         EX_FINAL: begin
            // Finish answers here once the result register is free.
            if (out_free) begin
               state_in = EX_IDLE;
               if (cur_ff.action == ACT_FINISH) begin
                  wr_finish = 1'b1;
                  ovalid_in = 1'b1;
                  oid_in    = 32'd0;
                  ost_in    = ST_NONE;
                  olast_in  = 1'b1;
               end
            end
         end
         default: state_in = EX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= EX_IDLE;
         now_ff     <= '0;
         next_id_ff <= '0;
         valid_ff   <= '0;
         fired_ff   <= '0;
         ovalid_ff  <= 1'b0;
         idx_ff     <= '0;
         found_ff   <= 1'b0;
         n_ff       <= '0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         now_ff     <= now_in;
         next_id_ff <= next_id_in;
         valid_ff   <= valid_in;
         fired_ff   <= fired_in;
         ovalid_ff  <= ovalid_in;
         idx_ff     <= idx_in;
         found_ff   <= found_in;
         n_ff       <= n_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      best_ff  <= best_in;
      oid_ff   <= oid_in;
      ost_ff   <= ost_in;
      olast_ff <= olast_in;
      for (int i = 0; i < QueueDepth; i++) begin
         if (wr_finish && valid_ff[i]) due_ff[i] <= now_ff;
      end
      if (wr_add) begin
         due_ff[best_ff]    <= now_ff + {16'd0, cur_ff.duration_ms};
         period_ff[best_ff] <= cur_ff.duration_ms;
         perio_ff[best_ff]  <= cur_ff.periodic;
         id_ff[best_ff]     <= next_id_ff;
      end
      if (wr_fire && perio_ff[best_ff]) due_ff[best_ff] <= fire_due;
   end

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_id)) else $error("hold");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> state_ff == EX_IDLE) else $error("take outside idle");
   a_burst: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CountBits'(MaxResults)) else $error("burst overrun");
`endif
endmodule

FILE: design/timed_event_scheduler_unit.sv
// Timed event scheduler: a 16-entry table of one-shot and periodic timers.
// req_ channel: action (add, remove, tick, finish) with its operands.
// rsp_ channel: one or more results per request; rsp_last marks the final one.
// Add, remove and a tick each scan the table at one slot per cycle: a request
// passes the queue, then the engine takes it, scans all 16 slots and emits
// the result into the result register. A tick that fires more than one
// event rescans the whole table before each further result. Finish
// answers without a scan, once the result register is free.
// A two-entry command queue decouples request acceptance from execution,
// and the result register holds its value while rsp_stall is high; a stalled
// result holds the engine at its next emit; req_stall rises on a full queue.
// Synchronous active-high reset clears time, ids and all table valid bits.
`timescale 1ns / 1ps
module timed_event_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_duration_ms,
   input  logic        req_periodic,
   input  logic [31:0] req_target_id,
   input  logic [31:0] req_elapsed_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_event_id,
   output logic [2:0]  rsp_status,
   output logic        rsp_last
);
   import tes_pkg::*;

   cmd_type wr_cmd, rd_cmd;
   logic    rd_valid, rd_take;

   always_comb begin
      wr_cmd.action      = action_type'(req_action);
      wr_cmd.duration_ms = req_duration_ms;
      wr_cmd.periodic    = req_periodic;
      wr_cmd.target_id   = req_target_id;
      wr_cmd.elapsed_ms  = req_elapsed_ms;
   end

   tes_cmd_fifo u_fifo (
      .clock(clock), .reset(reset),
      .wr_valid(req_valid), .wr_stall(req_stall), .wr_cmd(wr_cmd),
      .rd_valid(rd_valid), .rd_take(rd_take), .rd_cmd(rd_cmd)
   );

   tes_exec u_exec (
      .clock(clock), .reset(reset),
      .cmd_valid(rd_valid), .cmd_take(rd_take), .cmd(rd_cmd),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_event_id(rsp_event_id), .rsp_status(rsp_status), .rsp_last(rsp_last)
   );
endmodule
